// ===== design/epjc_pkg.sv =====
// Shared types, codes and constants of the joint position controller.
`timescale 1ns / 1ps
package epjc_pkg;

  // Input item of one transfer
  typedef struct packed {
    logic        command;
    logic [7:0]  hundreds_byte;
    logic [7:0]  tens_byte;
    logic [7:0]  ones_byte;
    logic [15:0] encoder_count;
    logic [31:0] time_ms;
  } epjc_in_t;

  // Result item of one transfer
  typedef struct packed {
    logic [15:0] drive_forward;
    logic [15:0] drive_reverse;
    logic        report_valid;
    logic [7:0]  report_hundreds;
    logic [3:0]  report_tens;
    logic [3:0]  report_ones;
  } epjc_out_t;

  localparam int OP_W = 5;

  // Datapath operation codes
  localparam logic [OP_W-1:0] OP_NONE      = 5'd0;
  localparam logic [OP_W-1:0] OP_LOAD      = 5'd1;
  localparam logic [OP_W-1:0] OP_TGT_LOAD  = 5'd2;
  localparam logic [OP_W-1:0] OP_DIV_STEP  = 5'd3;
  localparam logic [OP_W-1:0] OP_TGT_END   = 5'd4;
  localparam logic [OP_W-1:0] OP_RPT_CHK   = 5'd5;
  localparam logic [OP_W-1:0] OP_RPT_LOAD2 = 5'd6;
  localparam logic [OP_W-1:0] OP_RPT_LOAD3 = 5'd7;
  localparam logic [OP_W-1:0] OP_RPT_END   = 5'd8;
  localparam logic [OP_W-1:0] OP_UPD       = 5'd9;
  localparam logic [OP_W-1:0] OP_ERR       = 5'd10;
  localparam logic [OP_W-1:0] OP_DIFF      = 5'd11;
  localparam logic [OP_W-1:0] OP_P_MUL     = 5'd12;
  localparam logic [OP_W-1:0] OP_P_SAT     = 5'd13;
  localparam logic [OP_W-1:0] OP_E_SAT     = 5'd14;
  localparam logic [OP_W-1:0] OP_SUM       = 5'd15;
  localparam logic [OP_W-1:0] OP_ESMAG     = 5'd16;
  localparam logic [OP_W-1:0] OP_I_HI      = 5'd17;
  localparam logic [OP_W-1:0] OP_I_LO      = 5'd18;
  localparam logic [OP_W-1:0] OP_I_SAT     = 5'd19;
  localparam logic [OP_W-1:0] OP_D_HI      = 5'd20;
  localparam logic [OP_W-1:0] OP_ND        = 5'd21;
  localparam logic [OP_W-1:0] OP_DLOAD     = 5'd22;
  localparam logic [OP_W-1:0] OP_FINISH    = 5'd23;
  localparam logic [OP_W-1:0] OP_OUT       = 5'd24;

  // Configuration register indexes
  localparam logic [1:0] REG_GAIN_P   = 2'd0;
  localparam logic [1:0] REG_GAIN_I   = 2'd1;
  localparam logic [1:0] REG_GAIN_D   = 2'd2;
  localparam logic [1:0] REG_PERIOD   = 2'd3;

  // Derivative divider bit count, minus one
  localparam logic [5:0] CNT_D    = 6'd46;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } epjc_cmd_t;

  typedef struct packed {
    logic tick;
    logic rpt_due;
    logic d_skip;
    logic out_free;
  } epjc_status_t;

endpackage

// ===== design/epjc_ctrl.sv =====
// Sequencer of the joint position controller: steps the datapath through one item.
`timescale 1ns / 1ps
module epjc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  epjc_pkg::epjc_status_t status,
  output epjc_pkg::epjc_cmd_t    cmd
);
  import epjc_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DISP  = 5'd1;
  localparam logic [4:0] S_TLOAD = 5'd2;
  localparam logic [4:0] S_TEND  = 5'd3;
  localparam logic [4:0] S_RCHK  = 5'd4;
  localparam logic [4:0] S_RL2   = 5'd5;
  localparam logic [4:0] S_RL3   = 5'd6;
  localparam logic [4:0] S_REND  = 5'd7;
  localparam logic [4:0] S_UPD   = 5'd8;
  localparam logic [4:0] S_ERR   = 5'd9;
  localparam logic [4:0] S_DIFF  = 5'd10;
  localparam logic [4:0] S_PMUL  = 5'd11;
  localparam logic [4:0] S_PSAT  = 5'd12;
  localparam logic [4:0] S_ESAT  = 5'd13;
  localparam logic [4:0] S_SUM   = 5'd14;
  localparam logic [4:0] S_ESMAG = 5'd15;
  localparam logic [4:0] S_IHI   = 5'd16;
  localparam logic [4:0] S_ILO   = 5'd17;
  localparam logic [4:0] S_ISAT  = 5'd18;
  localparam logic [4:0] S_DHI   = 5'd19;
  localparam logic [4:0] S_ND    = 5'd20;
  localparam logic [4:0] S_DLOAD = 5'd21;
  localparam logic [4:0] S_DCHK  = 5'd22;
  localparam logic [4:0] S_DDIV  = 5'd23;
  localparam logic [4:0] S_FIN   = 5'd24;
  localparam logic [4:0] S_OUT   = 5'd25;

  logic [4:0] state, state_next;
  logic [5:0] cnt, cnt_next;

  assign in_ready = (state == S_IDLE);

  // Hold state and bit counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Pick the operation and advance
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd.op     = OP_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_DISP;
        end
      end
      S_DISP:  state_next = status.tick ? S_RCHK : S_TLOAD;
      S_TLOAD: begin
        cmd.op     = OP_TGT_LOAD;
        state_next = S_TEND;
      end
      S_TEND: begin
        cmd.op     = OP_TGT_END;
        state_next = S_IDLE;
      end
      S_RCHK: begin
        cmd.op = OP_RPT_CHK;
        if (status.rpt_due) begin
          state_next = S_RL2;
        end else begin
          state_next = S_UPD;
        end
      end
      S_RL2: begin
        cmd.op     = OP_RPT_LOAD2;
        state_next = S_RL3;
      end
      S_RL3: begin
        cmd.op     = OP_RPT_LOAD3;
        state_next = S_REND;
      end
      S_REND: begin
        cmd.op     = OP_RPT_END;
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.op     = OP_UPD;
        state_next = S_ERR;
      end
      S_ERR: begin
        cmd.op     = OP_ERR;
        state_next = S_DIFF;
      end
      S_DIFF: begin
        cmd.op     = OP_DIFF;
        state_next = S_PMUL;
      end
      S_PMUL: begin
        cmd.op     = OP_P_MUL;
        state_next = S_PSAT;
      end
      S_PSAT: begin
        cmd.op     = OP_P_SAT;
        state_next = S_ESAT;
      end
      S_ESAT: begin
        cmd.op     = OP_E_SAT;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.op     = OP_SUM;
        state_next = S_ESMAG;
      end
      S_ESMAG: begin
        cmd.op     = OP_ESMAG;
        state_next = S_IHI;
      end
      S_IHI: begin
        cmd.op     = OP_I_HI;
        state_next = S_ILO;
      end
      S_ILO: begin
        cmd.op     = OP_I_LO;
        state_next = S_ISAT;
      end
      S_ISAT: begin
        cmd.op     = OP_I_SAT;
        state_next = S_DHI;
      end
      S_DHI: begin
        cmd.op     = OP_D_HI;
        state_next = S_ND;
      end
      S_ND: begin
        cmd.op     = OP_ND;
        state_next = S_DLOAD;
      end
      S_DLOAD: begin
        cmd.op     = OP_DLOAD;
        state_next = S_DCHK;
      end
      S_DCHK: begin
        if (status.d_skip) begin
          state_next = S_FIN;
        end else begin
          cnt_next   = CNT_D;
          state_next = S_DDIV;
        end
      end
      S_DDIV: begin
        cmd.op = OP_DIV_STEP;
        if (cnt == '0) state_next = S_FIN;
        else cnt_next = cnt - 6'd1;
      end
      S_FIN: begin
        cmd.op     = OP_FINISH;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.op     = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== design/epjc_datapath.sv =====
// Datapath of the joint position controller: state, shared multiplier, serial divider.
`timescale 1ns / 1ps
module epjc_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [1:0]             cfg_index,
  input  logic [31:0]            cfg_data,
  input  epjc_pkg::epjc_in_t     in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output epjc_pkg::epjc_out_t    out_data,
  input  epjc_pkg::epjc_cmd_t    cmd,
  output epjc_pkg::epjc_status_t status
);
  import epjc_pkg::*;

  localparam logic [46:0] TERM_MAX = '1;
  localparam logic [48:0] E_LIM    = 49'h1_0000_0000_0000;
  localparam logic [49:0] SUM_HI   = 50'h0_7FFF_FFFF_FFFF;
  localparam logic [49:0] SUM_LO   = 50'h3_8000_0000_0000;
  // Reciprocal of 5 in Q0.34; bits 63:34 of x times this give x/5, bits 63:35 give x/10
  localparam logic [31:0] RECIP5   = 32'hCCCC_CCCD;
  // 7/125 scaled by 2^20, set slightly above the exact value; exact for the fraction of angles up to 650
  localparam logic [31:0] FRAC_MUL = 32'd58723;

  function automatic logic [46:0] sat47(input logic [66:0] x);
    return (x > {20'b0, TERM_MAX}) ? TERM_MAX : x[46:0];
  endfunction

  // Configuration and architectural state
  logic [31:0] gain_p, gain_i, gain_d;
  logic [5:0]  period;
  logic [31:0] position, last_time;
  logic [14:0] target;
  logic [32:0] last_error;
  logic [47:0] error_sum;
  logic [5:0]  report_count;

  // Work registers
  epjc_in_t    in_q;
  logic [32:0] err, err_mag;
  logic [31:0] dt;
  logic [33:0] diff, diff_mag;
  logic [63:0] prod, hi_reg;
  logic [46:0] p_mag, i_mag;
  logic [48:0] e_sat;
  logic [47:0] esmag;
  logic        i_neg;
  logic [66:0] nd;
  logic        d_zero, d_sat;
  logic [31:0] rem, dsr;
  logic [46:0] dvd, quo;
  logic        angle_ok, rpt_due, rpt_valid;
  logic [14:0] angle_q;
  logic [31:0] rpt_a, rpt_a10;
  logic [7:0]  rh;
  logic [3:0]  rt, ro;
  logic [49:0] drive;

  // Combinational helpers
  logic [31:0] mul_a, mul_b;
  logic [32:0] r2;
  logic        ge;
  logic [14:0] angle;
  logic [31:0] tgt_frac;
  logic [14:0] tgt_calc;
  logic [31:0] q5, q10;
  logic [31:0] pos_next, pos_mag;
  logic [64:0] t65, e65;
  logic [49:0] s50, e_signed;
  logic [49:0] pt, it, dterm;
  logic [46:0] d_mag;
  logic [49:0] drive_mag;
  logic [33:0] drive_shift;
  logic [15:0] m16;

  assign status.tick     = in_q.command;
  assign status.rpt_due  = (report_count == period);
  assign status.d_skip   = d_zero | d_sat;
  assign status.out_free = !out_valid || out_ready;

  assign angle = 15'(in_q.hundreds_byte) * 15'd100 + 15'(in_q.tens_byte) * 15'd10
               + {7'b0, in_q.ones_byte};
  // Scale by 40.056: whole part times 40 plus the 0.056 fraction
  assign tgt_frac = {17'b0, angle_q} * FRAC_MUL;
  assign tgt_calc = 15'({17'b0, angle_q} * 32'd40 + {20'b0, tgt_frac[31:20]});
  assign q5  = {2'b0, prod[63:34]};
  assign q10 = {3'b0, prod[63:35]};
  assign pos_next = position + {16'b0, in_q.encoder_count} - 32'd32768;
  assign pos_mag  = 32'd0 - position;

  // Divider step: shift one dividend bit into the remainder
  assign r2 = {rem, dvd[46]};
  assign ge = r2 >= {1'b0, dsr};

  assign t65 = {1'b0, prod} + (err_mag[32] ? {1'b0, gain_p, 32'b0} : 65'd0);
  assign e65 = {1'b0, prod} + (err_mag[32] ? {1'b0, dt, 32'b0} : 65'd0);
  assign e_signed = err[32] ? (50'd0 - {1'b0, e_sat}) : {1'b0, e_sat};
  assign s50 = {{2{error_sum[47]}}, error_sum} + e_signed;

  assign d_mag = d_zero ? 47'd0 : (d_sat ? TERM_MAX : quo);
  assign pt    = err[32] ? (50'd0 - {3'b0, p_mag}) : {3'b0, p_mag};
  assign it    = i_neg ? (50'd0 - {3'b0, i_mag}) : {3'b0, i_mag};
  assign dterm = diff[33] ? (50'd0 - {3'b0, d_mag}) : {3'b0, d_mag};

  assign drive_mag   = drive[49] ? (50'd0 - drive) : drive;
  assign drive_shift = drive_mag[49:16];
  assign m16 = (drive_shift > 34'd65530) ? 16'hFFFF : drive_shift[15:0];

  // Select the multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_RPT_CHK: begin
        mul_a = position[31] ? 32'd0 : {3'b0, position[31:3]};
        mul_b = RECIP5;
      end
      OP_RPT_LOAD2: begin
        mul_a = q5;
        mul_b = RECIP5;
      end
      OP_RPT_LOAD3: begin
        mul_a = q10;
        mul_b = RECIP5;
      end
      OP_P_MUL: begin
        mul_a = gain_p;
        mul_b = err_mag[31:0];
      end
      OP_P_SAT: begin
        mul_a = err_mag[31:0];
        mul_b = dt;
      end
      OP_I_HI: begin
        mul_a = gain_i;
        mul_b = esmag[47:16];
      end
      OP_I_LO: begin
        mul_a = gain_i;
        mul_b = {16'b0, esmag[15:0]};
      end
      OP_I_SAT: begin
        mul_a = gain_d;
        mul_b = diff_mag[31:0];
      end
      OP_D_HI: begin
        mul_a = gain_d;
        mul_b = {30'b0, diff_mag[33:32]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Hold configuration, architectural state and the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p       <= 32'd1966080;
      gain_i       <= 32'd1288490;
      gain_d       <= 32'd21626880;
      period       <= 6'd50;
      position     <= '0;
      target       <= '0;
      last_error   <= '0;
      error_sum    <= '0;
      last_time    <= '0;
      report_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_GAIN_P: gain_p <= cfg_data;
          REG_GAIN_I: gain_i <= cfg_data;
          REG_GAIN_D: gain_d <= cfg_data;
          REG_PERIOD: period <= cfg_data[5:0];
          default: ;
        endcase
      end
      // Load a new result or drop the one just transferred
      if (cmd.op == OP_OUT) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      case (cmd.op)
        OP_TGT_END: begin
          if (angle_ok) target <= tgt_calc;
          report_count <= 6'd1;
        end
        OP_UPD: begin
          position  <= pos_next;
          last_time <= in_q.time_ms;
        end
        OP_DIFF: last_error <= err;
        OP_SUM: begin
          if ($signed(s50) > $signed(SUM_HI)) error_sum <= SUM_HI[47:0];
          else if ($signed(s50) < $signed(SUM_LO)) error_sum <= SUM_LO[47:0];
          else error_sum <= s50[47:0];
        end
        OP_OUT: report_count <= rpt_due ? 6'd1 : report_count + 6'd1;
        default: ;
      endcase
    end
  end

  // Work registers, advanced by the sequencer's operation
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: in_q <= in_data;
      OP_TGT_LOAD: begin
        angle_ok <= (angle <= 15'd650);
        angle_q  <= angle;
      end
      OP_DIV_STEP: begin
        rem <= ge ? 32'(r2 - {1'b0, dsr}) : r2[31:0];
        dvd <= {dvd[45:0], 1'b0};
        quo <= {quo[45:0], ge};
      end
      OP_RPT_CHK: begin
        rpt_due   <= status.rpt_due;
        rpt_valid <= status.rpt_due && (!position[31] || (pos_mag < 32'd40));
        rh        <= '0;
        rt        <= '0;
        ro        <= '0;
        prod      <= mul_a * mul_b;
      end
      OP_RPT_LOAD2: begin
        rpt_a <= q5;
        prod  <= mul_a * mul_b;
      end
      OP_RPT_LOAD3: begin
        rpt_a10 <= q10;
        ro      <= rpt_valid ? 4'(rpt_a - 32'd10 * q10) : 4'd0;
        prod    <= mul_a * mul_b;
      end
      OP_RPT_END: begin
        if (rpt_valid) begin
          rt <= 4'(rpt_a10 - 32'd10 * q10);
          rh <= q10[7:0];
        end
      end
      OP_UPD: dt <= in_q.time_ms - last_time;
      OP_ERR: err <= {position[31], position} - {18'b0, target};
      OP_DIFF: begin
        diff    <= {err[32], err} - {last_error[32], last_error};
        err_mag <= err[32] ? (33'd0 - err) : err;
      end
      OP_P_MUL: begin
        prod     <= mul_a * mul_b;
        diff_mag <= diff[33] ? (34'd0 - diff) : diff;
      end
      OP_P_SAT: begin
        p_mag <= sat47({2'b0, t65});
        prod  <= mul_a * mul_b;
      end
      OP_E_SAT: e_sat <= (e65 > {16'b0, E_LIM}) ? E_LIM : e65[48:0];
      OP_ESMAG: begin
        esmag <= error_sum[47] ? (48'd0 - error_sum) : error_sum;
        i_neg <= error_sum[47];
      end
      OP_I_HI: prod <= mul_a * mul_b;
      OP_I_LO: begin
        hi_reg <= prod;
        prod   <= mul_a * mul_b;
      end
      OP_I_SAT: begin
        i_mag <= sat47({3'b0, hi_reg} + {19'b0, prod[63:16]});
        prod  <= mul_a * mul_b;
      end
      OP_D_HI: begin
        hi_reg <= prod;
        prod   <= mul_a * mul_b;
      end
      OP_ND: nd <= {prod[34:0], 32'b0} + {3'b0, hi_reg};
      OP_DLOAD: begin
        d_zero <= (dt == 32'd0);
        d_sat  <= ({12'b0, nd[66:47]} >= dt);
        rem    <= {12'b0, nd[66:47]};
        dvd    <= nd[46:0];
        quo    <= '0;
        dsr    <= dt;
      end
      OP_FINISH: drive <= pt + it + dterm;
      OP_OUT: begin
        out_data.drive_forward   <= drive[49] ? 16'd0 : m16;
        out_data.drive_reverse   <= drive[49] ? m16 : 16'd0;
        out_data.report_valid    <= rpt_valid;
        out_data.report_hundreds <= rh;
        out_data.report_tens     <= rt;
        out_data.report_ones     <= ro;
      end
      default: ;
    endcase
  end

endmodule

// ===== design/encoder_pid_joint_controller_top.sv =====
// Top level of the encoder PID joint controller.
`timescale 1ns / 1ps
// Position controller for one motor joint, one item at a time. A target item
// passes through the load, dispatch, target load and target end states (the
// angle scale by 40.056 is done with constant multiplies). A tick runs 20 fixed
// steps that share one 32x32 multiplier, plus 47 steps of the serial divider for
// the derivative term (skipped when the elapsed time is zero or the term
// saturates). A tick that sends a position report adds the report states for the
// divides by 40 and by 10, done by reciprocal multiplication on the shared
// multiplier. Input is taken only between items; a finished result waits in the
// output register while the next item is taken, and the next tick holds in its
// last step until that register is free.
module encoder_pid_joint_controller_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  epjc_pkg::epjc_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output epjc_pkg::epjc_out_t out_data
);
  import epjc_pkg::*;

  epjc_cmd_t    cmd;
  epjc_status_t status;

  // Sequence each item
  epjc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Hold state and compute
  epjc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// ===== tb/encoder_pid_joint_controller_top_tb.sv =====
// Self-checking testbench of the encoder PID joint controller top level.
`timescale 1ns / 1ps

// Predicts the drive and report of each control tick and holds them until they arrive
class joint_scoreboard;
  localparam bit [63:0] TERM_LIM = 64'h7FFF_FFFF_FFFF;
  localparam longint SUM_HI = 64'sh7FFF_FFFF_FFFF;
  localparam longint SUM_LO = -64'sh8000_0000_0000;

  bit [31:0] gain_p, gain_i, gain_d;
  bit [5:0]  period;
  bit [31:0] position, last_time;
  bit [14:0] target;
  bit [5:0]  tick_count;
  longint    last_err, err_sum;
  epjc_pkg::epjc_out_t drives_due[$];
  int errors;

  function void reset_state();
    gain_p = 32'd1966080;
    gain_i = 32'd1288490;
    gain_d = 32'd21626880;
    period = 6'd50;
    position = '0;
    last_time = '0;
    target = '0;
    tick_count = '0;
    last_err = 0;
    err_sum = 0;
    drives_due.delete();
    errors = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [31:0] val);
    case (idx)
      epjc_pkg::REG_GAIN_P: gain_p = val;
      epjc_pkg::REG_GAIN_I: gain_i = val;
      epjc_pkg::REG_GAIN_D: gain_d = val;
      epjc_pkg::REG_PERIOD: period = val[5:0];
      default: ;
    endcase
  endfunction

  function bit [63:0] magnitude(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function longint signed_of(bit neg, bit [63:0] m);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function bit [63:0] clamp_mul(bit [63:0] a, bit [63:0] b, bit [63:0] lim);
    bit [63:0] p;
    if (a == 0) return '0;
    if (b > lim / a) return lim;
    p = a * b;
    return p > lim ? lim : p;
  endfunction

  // Advance the controller by one accepted input and queue what it should send
  function void note_input(epjc_pkg::epjc_in_t it);
    epjc_pkg::epjc_out_t res;
    bit [31:0] angle, quot, neg_mag, dt;
    bit [63:0] m, prod, v, k;
    bit [127:0] q;
    longint err, diff, p_term, i_term, d_term, drive;
    if (!it.command) begin
      angle = 32'(it.hundreds_byte) * 100 + 32'(it.tens_byte) * 10 + 32'(it.ones_byte);
      if (angle <= 650) target = 15'(angle * 40056 / 1000);
      tick_count = 6'd1;
      return;
    end
    res = '0;
    // report the position from before this tick
    if (tick_count == period) begin
      quot = '0;
      neg_mag = -position;
      if (!position[31]) quot = position / 40;
      if (!position[31] || neg_mag < 40) begin
        res.report_valid = 1'b1;
        res.report_hundreds = 8'(quot / 100);
        res.report_tens = 4'((quot / 10) % 10);
        res.report_ones = 4'(quot % 10);
      end
      tick_count = '0;
    end
    position = position + 32'(it.encoder_count) - 32'd32768;
    dt = it.time_ms - last_time;
    last_time = it.time_ms;
    err = longint'($signed(position)) - longint'(target);
    p_term = signed_of(err < 0, clamp_mul(64'(gain_p), magnitude(err), TERM_LIM));
    // integrate with saturation
    prod = clamp_mul(magnitude(err), 64'(dt), 64'd1 << 48);
    err_sum += signed_of(err < 0, prod);
    if (err_sum > SUM_HI) err_sum = SUM_HI;
    if (err_sum < SUM_LO) err_sum = SUM_LO;
    m = magnitude(err_sum);
    k = 64'(gain_i);
    v = k * (m >> 16) + ((k * (m & 64'hFFFF)) >> 16);
    i_term = signed_of(err_sum < 0, v > TERM_LIM ? TERM_LIM : v);
    // derivative, zero when no time elapsed
    diff = err - last_err;
    d_term = 0;
    if (dt != 0) begin
      q = (128'(gain_d) * 128'(magnitude(diff))) / 128'(dt);
      d_term = signed_of(diff < 0, q > 128'(TERM_LIM) ? TERM_LIM : q[63:0]);
    end
    last_err = err;
    drive = p_term + i_term + d_term;
    m = magnitude(drive) >> 16;
    if (m > 64'd65530) m = 64'd65535;
    if (drive >= 0) res.drive_forward = m[15:0];
    else res.drive_reverse = m[15:0];
    tick_count = tick_count + 6'd1;
    drives_due.push_back(res);
  endfunction

  task report(string field, longint got, longint want);
    $display("mismatch on %s: got %0d, expected %0d", field, got, want);
    errors++;
  endtask

  // Compare one transfer from the block with the oldest expectation
  task check_result(epjc_pkg::epjc_out_t got);
    epjc_pkg::epjc_out_t want;
    if (drives_due.size() == 0) begin
      $display("unexpected result transfer");
      errors++;
      return;
    end
    want = drives_due.pop_front();
    if (got.drive_forward !== want.drive_forward)
      report("drive_forward", got.drive_forward, want.drive_forward);
    if (got.drive_reverse !== want.drive_reverse)
      report("drive_reverse", got.drive_reverse, want.drive_reverse);
    if (got.report_valid !== want.report_valid)
      report("report_valid", got.report_valid, want.report_valid);
    if (got.report_hundreds !== want.report_hundreds)
      report("report_hundreds", got.report_hundreds, want.report_hundreds);
    if (got.report_tens !== want.report_tens)
      report("report_tens", got.report_tens, want.report_tens);
    if (got.report_ones !== want.report_ones)
      report("report_ones", got.report_ones, want.report_ones);
  endtask
endclass

module encoder_pid_joint_controller_top_tb;
  import epjc_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  epjc_in_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  epjc_out_t   out_data;

  joint_scoreboard sb = new();
  bit [31:0] now_ms = '0;
  bit        no_gaps = 1'b0;
  bit        hold_req = 1'b0;
  int        cycle_count = 0;

  encoder_pid_joint_controller_top i_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #6 clk = ~clk;

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receive results with random stalls and one long hold-off on request
  initial begin : receiver
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) sb.check_result(out_data);
      if (hold_req && hold_left == 0) begin
        hold_left = 600;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (no_gaps || $urandom_range(99) < 70) begin
        out_ready <= 1'b1;
      end else begin
        stall_left = ($urandom_range(19) == 0) ? $urandom_range(60, 20) : $urandom_range(2);
        out_ready <= 1'b0;
      end
    end
  end

  // Offer one item after a random gap and hold it until the transfer
  task send_item(epjc_in_t it);
    int gap;
    gap = 0;
    if (!no_gaps) begin
      if ($urandom_range(19) == 0) gap = $urandom_range(60, 10);
      else if ($urandom_range(99) < 40) gap = $urandom_range(3, 1);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
  endtask

  // Let every result drain and the block settle before touching registers
  task wait_idle();
    in_valid <= 1'b0;
    while (sb.drives_due.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  function epjc_in_t target_frame(logic [7:0] h, logic [7:0] t, logic [7:0] o);
    epjc_in_t it;
    it = 73'({$urandom, $urandom, $urandom});
    it.command = 1'b0;
    it.hundreds_byte = h;
    it.tens_byte = t;
    it.ones_byte = o;
    return it;
  endfunction

  function epjc_in_t tick(logic [15:0] enc, logic [31:0] ms);
    epjc_in_t it;
    it = 73'({$urandom, $urandom, $urandom});
    it.command = 1'b1;
    it.encoder_count = enc;
    it.time_ms = ms;
    return it;
  endfunction

  // Random mix of targets and ticks; tgt_pct sets how often a new target arrives
  task run_phase(int n, int tgt_pct, bit pressure);
    epjc_in_t it;
    int r;
    for (int i = 0; i < n; i++) begin
      if (pressure && i == n / 3) hold_req = 1'b1;
      if ($urandom_range(99) < tgt_pct) begin
        if ($urandom_range(4) != 0)
          it = target_frame(8'($urandom_range(6)), 8'($urandom_range(9)),
                            8'($urandom_range(9)));
        else
          it = target_frame(8'($urandom), 8'($urandom), 8'($urandom));
      end else begin
        r = $urandom_range(9);
        case (r)
          0, 1, 2, 3, 4, 5: it.encoder_count = 16'(32768 + $urandom_range(400) - 200);
          6, 7: it.encoder_count = 16'(32768 + $urandom_range(8000) - 4000);
          8: it.encoder_count = 16'($urandom);
          default: it.encoder_count = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        endcase
        r = $urandom_range(9);
        case (r)
          7: ;
          8: now_ms = $urandom;
          9: now_ms = now_ms + $urandom_range(100000, 1000);
          default: now_ms = now_ms + $urandom_range(10, 1);
        endcase
        it = tick(it.encoder_count, now_ms);
      end
      send_item(it);
    end
  endtask

  initial begin : stimulus
    sb.reset_state();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: report every tick, so the negative position cases show up
    write_reg(REG_PERIOD, 32'd1);
    send_item(target_frame(8'd0, 8'd0, 8'd0));
    send_item(tick(16'd32748, 32'd5));
    send_item(target_frame(8'd0, 8'd0, 8'd0));
    send_item(tick(16'd32668, 32'd5));
    send_item(target_frame(8'd6, 8'd5, 8'd0));
    send_item(tick(16'd32768, 32'd9));
    send_item(target_frame(8'd6, 8'd5, 8'd1));
    send_item(tick(16'hFFFF, 32'hFFFF_FFFF));
    send_item(target_frame(8'hFF, 8'hFF, 8'hFF));
    send_item(tick(16'h0000, 32'd0));
    send_item(target_frame(8'd0, 8'd65, 8'd0));
    send_item(tick(16'h0000, 32'd0));
    send_item(tick(16'h0000, 32'd1));
    send_item(target_frame(8'd3, 8'd2, 8'd7));
    send_item(tick(16'hFFFF, 32'd2));
    send_item(tick(16'hFFFF, 32'd2));
    send_item(tick(16'd40000, 32'h8000_0000));
    send_item(tick(16'd32768, 32'h8000_0001));
    now_ms = 32'h8000_0001;
    wait_idle();

    // Reset gains, default period
    write_reg(REG_PERIOD, 32'd50);
    run_phase(320, 3, 1'b0);
    wait_idle();

    // Largest gains, report every tick
    write_reg(REG_GAIN_P, 32'hFFFF_FFFF);
    write_reg(REG_GAIN_I, 32'hFFFF_FFFF);
    write_reg(REG_GAIN_D, 32'hFFFF_FFFF);
    write_reg(REG_PERIOD, 32'd1);
    run_phase(300, 20, 1'b1);
    wait_idle();

    // Zero gains, longest period, no idling
    write_reg(REG_GAIN_P, 32'd0);
    write_reg(REG_GAIN_I, 32'd0);
    write_reg(REG_GAIN_D, 32'd0);
    write_reg(REG_PERIOD, 32'd63);
    no_gaps = 1'b1;
    run_phase(300, 1, 1'b0);
    wait_idle();
    no_gaps = 1'b0;

    // Random gains, period zero so the count must wrap
    write_reg(REG_GAIN_P, $urandom);
    write_reg(REG_GAIN_I, $urandom);
    write_reg(REG_GAIN_D, $urandom);
    write_reg(REG_PERIOD, 32'd0);
    run_phase(300, 1, 1'b0);
    wait_idle();

    // Moderate random gains, short periods
    write_reg(REG_GAIN_P, $urandom_range(32'h0100_0000));
    write_reg(REG_GAIN_I, $urandom_range(32'h0100_0000));
    write_reg(REG_GAIN_D, $urandom_range(32'h1000_0000));
    write_reg(REG_PERIOD, $urandom_range(8, 2));
    run_phase(320, 12, 1'b0);
    wait_idle();

    if (sb.errors == 0 && sb.drives_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
